[rtl/core/pida_pkg.sv]
// ----------------------------------------------------------------------------
// pida_pkg
// Shared types and constants for the positional insert/delete array: the
// command and status codes, the request and response words, and the control
// word that the top level broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package pida_pkg;

   // Capacity of the array and the index width of one cell.
   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);

   // Widths fixed by the request and response fields.
   localparam int CNT_W  = 7;
   localparam int DATA_W = 32;

   // Command codes.
   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_INSERT = 2'd2,
      CMD_DELETE = 2'd3
   } cmd_type;

   // Status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // One request word.
   typedef struct packed {
      cmd_type                    command;
      logic signed [DATA_W-1:0]   value;
      logic        [CNT_W-1:0]    position;
   } req_type;

   // One response word.
   typedef struct packed {
      status_type                 status;
      logic signed [DATA_W-1:0]   popped_value;
      logic        [CNT_W-1:0]    element_count;
   } rsp_type;

   // Control word broadcast to every cell in the row.
   typedef struct packed {
      logic                       shift_up;
      logic                       shift_down;
      logic        [CNT_W-1:0]    position;
      logic        [DATA_W-1:0]   value;
      logic        [IDX_W-1:0]    read_index;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[rtl/core/pida_cell.sv]
// ----------------------------------------------------------------------------
// pida_cell
// One storage cell of the array. On an insert it takes its left neighbor's
// word when it sits above the position, or the new word at the position; on
// a delete it takes its right neighbor's word from the position upward. It
// also drives its word onto the read bus when it is the selected entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pida_cell (
   input  wire logic                            clock,
   input  wire logic [pida_pkg::IDX_W-1:0]      cell_index,
   input  wire pida_pkg::cell_ctrl_type         ctrl,
   input  wire logic [pida_pkg::DATA_W-1:0]     left_data,
   input  wire logic [pida_pkg::DATA_W-1:0]     right_data,
   output logic      [pida_pkg::DATA_W-1:0]     data_out,
   output logic      [pida_pkg::DATA_W-1:0]     read_data
);

   logic [pida_pkg::DATA_W-1:0] data_ff;
   logic [pida_pkg::DATA_W-1:0] data_in;
   logic [pida_pkg::CNT_W-1:0]  index_wide;

   assign index_wide = pida_pkg::CNT_W'(cell_index);

   // Next word: shift up, shift down or hold.
   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_up) begin
         if (index_wide > ctrl.position) begin
            data_in = left_data;
         end else if (index_wide == ctrl.position) begin
            data_in = ctrl.value;
         end
      end else if (ctrl.shift_down) begin
         if (index_wide >= ctrl.position) begin
            data_in = right_data;
         end
      end
   end

   // Storage word; no reset, entries are read only after being written.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out  = data_ff;
   assign read_data = (cell_index == ctrl.read_index) ? data_ff : '0;

endmodule

`default_nettype wire

[rtl/core/positional_insert_delete_array.sv]
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Ordered array of signed 32-bit words with push, pop, insert at a position
// and delete at a position, built as a row of cells that shift in parallel.
// ----------------------------------------------------------------------------
// The response word is registered: it appears in the cycle after the request is accepted.
// Throughput: one command per cycle while the response side takes its words; every cell compares its index with the
// position and loads from its neighbor in the same cycle as the command.
// The response register frees as it is taken, so back-to-back words flow.
// Reset clears the element count and the response valid; cell contents are
// left as they are and are read only after being written.
`default_nettype none

module positional_insert_delete_array (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pida_pkg::req_type req_word,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pida_pkg::rsp_type      rsp_word
);

   logic                          req_fire;
   logic [pida_pkg::CNT_W-1:0]    count_ff;
   logic [pida_pkg::CNT_W-1:0]    count_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   pida_pkg::rsp_type             rsp_ff;
   pida_pkg::rsp_type             rsp_in;
   pida_pkg::cell_ctrl_type       ctrl;
   pida_pkg::status_type          status;
   logic                          is_full;
   logic                          is_empty;
   logic [pida_pkg::CNT_W-1:0]    count_dec;
   logic [pida_pkg::DATA_W-1:0]   cell_data [pida_pkg::DEPTH];
   logic [pida_pkg::DATA_W-1:0]   cell_read [pida_pkg::DEPTH];
   logic [pida_pkg::DATA_W-1:0]   pop_data;

   // Handshake: take a word whenever the response register is free or leaving.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign is_full   = (count_ff == pida_pkg::CNT_W'(pida_pkg::DEPTH));
   assign is_empty  = (count_ff == '0);
   assign count_dec = count_ff - pida_pkg::CNT_W'(1);

   // Command decode: status and the control word for the cell row.
   always_comb begin
      status          = pida_pkg::ST_OK;
      count_in        = count_ff;
      ctrl.shift_up   = 1'b0;
      ctrl.shift_down = 1'b0;
      ctrl.position   = req_word.position;
      ctrl.value      = req_word.value;
      ctrl.read_index = count_dec[pida_pkg::IDX_W-1:0];
      unique case (req_word.command)
         pida_pkg::CMD_PUSH: begin
            ctrl.position = count_ff;
            if (is_full) begin
               status = pida_pkg::ST_FULL;
            end else begin
               ctrl.shift_up = req_fire;
               count_in      = count_ff + pida_pkg::CNT_W'(1);
            end
         end
         pida_pkg::CMD_POP: begin
            if (is_empty) begin
               status = pida_pkg::ST_EMPTY;
            end else begin
               count_in = count_dec;
            end
         end
         pida_pkg::CMD_INSERT: begin
            if (req_word.position > count_ff) begin
               status = pida_pkg::ST_RANGE;
            end else if (is_full) begin
               status = pida_pkg::ST_FULL;
            end else begin
               ctrl.shift_up = req_fire;
               count_in      = count_ff + pida_pkg::CNT_W'(1);
            end
         end
         pida_pkg::CMD_DELETE: begin
            if (req_word.position >= count_ff) begin
               status = pida_pkg::ST_RANGE;
            end else begin
               ctrl.shift_down = req_fire;
               count_in        = count_dec;
            end
         end
         default: begin
            status = pida_pkg::ST_OK;
         end
      endcase
   end

   // Row of storage cells, each linked to its two neighbors.
   for (genvar i = 0; i < pida_pkg::DEPTH; i++) begin : g_cell
      logic [pida_pkg::DATA_W-1:0] left_data;
      logic [pida_pkg::DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
      end

      if (i == pida_pkg::DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
      end

      pida_cell u_cell (
         .clock      (clock),
         .cell_index (pida_pkg::IDX_W'(i)),
         .ctrl       (ctrl),
         .left_data  (left_data),
         .right_data (right_data),
         .data_out   (cell_data[i]),
         .read_data  (cell_read[i])
      );
   end

   // Collect the last word for a pop; only the selected cell drives nonzero.
   always_comb begin
      pop_data = '0;
      for (int i = 0; i < pida_pkg::DEPTH; i++) begin
         pop_data = pop_data | cell_read[i];
      end
   end

   // Response word.
   always_comb begin
      rsp_in.status        = status;
      rsp_in.element_count = count_in;
      if (req_word.command == pida_pkg::CMD_POP && !is_empty) begin
         rsp_in.popped_value = pop_data;
      end else begin
         rsp_in.popped_value = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            count_ff <= count_in;
         end
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // The element count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pida_pkg::CNT_W'(pida_pkg::DEPTH))
      else $error("element count exceeds capacity");

   // An accepted word always yields a response in the next cycle.
   a_fire_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted word produced no response");

   // The pending response reports the current element count.
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.element_count == count_ff)
      else $error("response count disagrees with stored count");

   // A failed command leaves the count unchanged.
   a_fail_hold: assert property (@(posedge clock) disable iff (reset)
      req_fire && status != pida_pkg::ST_OK |=> count_ff == $past(count_ff))
      else $error("failed command changed the count");

   // A failed command's response carries a zero popped value.
   a_pop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != pida_pkg::ST_OK |-> rsp_ff.popped_value == '0)
      else $error("failed command returned a popped word");

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional insert/delete array. A short table
// of directed commands covers the empty and out-of-range cases. A long
// run of random commands follows, which alternates between filling the array
// and draining it. Every response word is checked against a behavioral copy
// of the array. Both handshakes idle at random, and once the response side
// holds off long enough to back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int RANDOM_WORDS = 1000;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 4;

   // One row of the directed table. The typed answer is used where "typed" is set.
   typedef struct {
      pida_pkg::req_type word;
      bit                typed;
      pida_pkg::rsp_type answer;
   } directed_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   pida_pkg::req_type req_word;
   logic              rsp_valid;
   logic              rsp_ready;
   pida_pkg::rsp_type rsp_word;

   // Side information that travels with the word on offer.
   bit                word_typed;
   pida_pkg::rsp_type word_answer;

   // Behavioral copy of the array.
   logic signed [pida_pkg::DATA_W-1:0] stored_words [pida_pkg::DEPTH];
   int                                 stored_count;

   pida_pkg::rsp_type expected_responses [$];
   int                error_count;
   bit                growing;
   bit                hold_off_pending;

   positional_insert_delete_array dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Applies one command to the stored copy and returns the response it yields.
   function automatic pida_pkg::rsp_type apply_command(pida_pkg::req_type w);
      pida_pkg::rsp_type r;
      int                i;
      r.status       = pida_pkg::ST_OK;
      r.popped_value = '0;
      case (w.command)
         pida_pkg::CMD_PUSH: begin
            if (stored_count >= pida_pkg::DEPTH) begin
               r.status = pida_pkg::ST_FULL;
            end else begin
               stored_words[stored_count] = w.value;
               stored_count++;
            end
         end
         pida_pkg::CMD_POP: begin
            if (stored_count == 0) begin
               r.status = pida_pkg::ST_EMPTY;
            end else begin
               stored_count--;
               r.popped_value = stored_words[stored_count];
            end
         end
         pida_pkg::CMD_INSERT: begin
            // The range check comes before the full check.
            if (int'(w.position) > stored_count) begin
               r.status = pida_pkg::ST_RANGE;
            end else if (stored_count >= pida_pkg::DEPTH) begin
               r.status = pida_pkg::ST_FULL;
            end else begin
               for (i = stored_count; i > int'(w.position); i--) begin
                  stored_words[i] = stored_words[i-1];
               end
               stored_words[w.position] = w.value;
               stored_count++;
            end
         end
         default: begin
            if (int'(w.position) >= stored_count) begin
               r.status = pida_pkg::ST_RANGE;
            end else begin
               for (i = int'(w.position) + 1; i < stored_count; i++) begin
                  stored_words[i-1] = stored_words[i];
               end
               stored_count--;
            end
         end
      endcase
      r.element_count = pida_pkg::CNT_W'(stored_count);
      return r;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 30);
   endfunction

   function automatic directed_row_type make_row(pida_pkg::cmd_type c,
                                                 logic signed [pida_pkg::DATA_W-1:0] v,
                                                 logic [pida_pkg::CNT_W-1:0] p, bit typed,
                                                 pida_pkg::status_type st,
                                                 logic signed [pida_pkg::DATA_W-1:0] pv,
                                                 logic [pida_pkg::CNT_W-1:0] cnt);
      directed_row_type row;
      row.word.command            = c;
      row.word.value              = v;
      row.word.position           = p;
      row.typed                   = typed;
      row.answer.status           = st;
      row.answer.popped_value     = pv;
      row.answer.element_count    = cnt;
      return row;
   endfunction

   // Random command, biased toward filling or draining the array by phase.
   function automatic pida_pkg::req_type random_word();
      pida_pkg::req_type w;
      int                r;
      // Switch phase mostly at the ends, sometimes in the middle.
      if (growing && stored_count == pida_pkg::DEPTH && $urandom_range(0, 3) == 0) begin
         growing = 1'b0;
      end else if (!growing && stored_count == 0 && $urandom_range(0, 3) == 0) begin
         growing = 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
         growing = !growing;
      end
      r = $urandom_range(0, 9);
      if (growing) begin
         w.command = (r < 4) ? pida_pkg::CMD_PUSH : (r < 8) ? pida_pkg::CMD_INSERT :
                     (r < 9) ? pida_pkg::CMD_POP : pida_pkg::CMD_DELETE;
      end else begin
         w.command = (r < 4) ? pida_pkg::CMD_POP : (r < 8) ? pida_pkg::CMD_DELETE :
                     (r < 9) ? pida_pkg::CMD_PUSH : pida_pkg::CMD_INSERT;
      end
      // Values: mostly random, sometimes the extremes.
      case ($urandom_range(0, 19))
         0:       w.value = 32'sh7FFF_FFFF;
         1:       w.value = 32'sh8000_0000;
         2:       w.value = -32'sd1;
         3:       w.value = 32'sd0;
         default: w.value = $urandom;
      endcase
      // Positions: mostly legal for the current count, sometimes anything.
      if ($urandom_range(0, 3) == 0) begin
         w.position = pida_pkg::CNT_W'($urandom_range(0, 127));
      end else if (w.command == pida_pkg::CMD_DELETE) begin
         w.position = (stored_count > 0) ?
                      pida_pkg::CNT_W'($urandom_range(0, stored_count - 1)) : '0;
      end else begin
         w.position = pida_pkg::CNT_W'($urandom_range(0, stored_count));
      end
      return w;
   endfunction

   // Offers one word after an idle gap and waits until it is taken.
   task automatic drive_word(input pida_pkg::req_type w, input bit typed,
                             input pida_pkg::rsp_type answer, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_word    <= w;
      word_typed  <= typed;
      word_answer <= answer;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Reset from time zero, released at a falling edge.
   initial begin
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Response side: random ready with one long hold-off on request.
   initial begin : receiver
      int run;
      int pause;
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         rsp_ready <= 1'b1;
         repeat (run) @(negedge clock);
         pause = pick_gap();
         if (pause > 0) begin
            rsp_ready <= 1'b0;
            repeat (pause) @(negedge clock);
         end
      end
   end

   // Handshake monitor: checks each response word, predicts each accepted command.
   always @(posedge clock) begin
      pida_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_responses.size() == 0) begin
               $display("%0t: response word with none expected: %p", $realtime, rsp_word);
               error_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_word.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d", $realtime,
                           want.status, rsp_word.status);
                  error_count++;
               end
               if (rsp_word.popped_value !== want.popped_value) begin
                  $display("%0t: popped_value expected %0d, got %0d", $realtime,
                           want.popped_value, rsp_word.popped_value);
                  error_count++;
               end
               if (rsp_word.element_count !== want.element_count) begin
                  $display("%0t: element_count expected %0d, got %0d", $realtime,
                           want.element_count, rsp_word.element_count);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            want = apply_command(req_word);
            expected_responses.push_back(word_typed ? word_answer : want);
         end
      end
   end

   // Stimulus: directed table, then the random run, then the drain.
   initial begin : stimulus
      directed_row_type script [$];
      int               n;
      bit               burst;
      req_valid        = 1'b0;
      req_word         = '0;
      word_typed       = 1'b0;
      word_answer      = '0;
      stored_count     = 0;
      error_count      = 0;
      growing          = 1'b1;
      hold_off_pending = 1'b0;
      burst            = 1'b0;

      // Empty array: pop, delete and insert past the count all fail.
      script.push_back(make_row(pida_pkg::CMD_POP, 0, 0, 1, pida_pkg::ST_EMPTY, 0, 0));
      script.push_back(make_row(pida_pkg::CMD_DELETE, 0, 0, 1, pida_pkg::ST_RANGE, 0, 0));
      script.push_back(make_row(pida_pkg::CMD_INSERT, 1, 1, 1, pida_pkg::ST_RANGE, 0, 0));
      // Build up with extreme values, inserting at zero and at the count.
      script.push_back(make_row(pida_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 0, 1,
                                pida_pkg::ST_OK, 0, 1));
      script.push_back(make_row(pida_pkg::CMD_PUSH, 32'sh8000_0000, 127, 1,
                                pida_pkg::ST_OK, 0, 2));
      script.push_back(make_row(pida_pkg::CMD_INSERT, -32'sd1, 0, 1, pida_pkg::ST_OK, 0, 3));
      script.push_back(make_row(pida_pkg::CMD_INSERT, 0, 3, 1, pida_pkg::ST_OK, 0, 4));
      script.push_back(make_row(pida_pkg::CMD_INSERT, 32'sh1234_5678, 2, 1,
                                pida_pkg::ST_OK, 0, 5));
      // Positions at and past the count.
      script.push_back(make_row(pida_pkg::CMD_DELETE, 0, 5, 1, pida_pkg::ST_RANGE, 0, 5));
      script.push_back(make_row(pida_pkg::CMD_DELETE, 0, 127, 1, pida_pkg::ST_RANGE, 0, 5));
      script.push_back(make_row(pida_pkg::CMD_INSERT, 55, 127, 1, pida_pkg::ST_RANGE, 0, 5));
      script.push_back(make_row(pida_pkg::CMD_DELETE, 0, 0, 1, pida_pkg::ST_OK, 0, 4));
      script.push_back(make_row(pida_pkg::CMD_POP, 0, 0, 1, pida_pkg::ST_OK, 0, 3));
      // Mixed moves checked against the stored copy, then drain to empty.
      script.push_back(make_row(pida_pkg::CMD_DELETE, 0, 1, 0, pida_pkg::ST_OK, 0, 0));
      script.push_back(make_row(pida_pkg::CMD_POP, 0, 64, 0, pida_pkg::ST_OK, 0, 0));
      script.push_back(make_row(pida_pkg::CMD_INSERT, 32'shA5A5_A5A5, 1, 0,
                                pida_pkg::ST_OK, 0, 0));
      script.push_back(make_row(pida_pkg::CMD_POP, 0, 0, 0, pida_pkg::ST_OK, 0, 0));
      script.push_back(make_row(pida_pkg::CMD_POP, 0, 0, 0, pida_pkg::ST_OK, 0, 0));
      script.push_back(make_row(pida_pkg::CMD_POP, 0, 0, 1, pida_pkg::ST_EMPTY, 0, 0));

      wait (!reset);
      @(negedge clock);

      foreach (script[i]) begin
         drive_word(script[i].word, script[i].typed, script[i].answer, pick_gap());
      end

      for (n = 0; n < RANDOM_WORDS; n++) begin
         // Some stretches of the run offer words back to back.
         if (n % 64 == 0) begin
            burst = ($urandom_range(0, 3) == 0);
         end
         // Ask the response side to back the block up while words keep coming.
         if (n == 300) begin
            hold_off_pending = 1'b1;
         end
         drive_word(random_word(), 1'b0, '0, burst ? 0 : pick_gap());
      end
      req_valid <= 1'b0;

      // Wait for every response, then wait on for stray words.
      while (expected_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
